>>> src/prws_pkg.sv
// Package for the read window scheduler: sizes, codes, state enums and the
// command/status structs between controller and datapath. No dependencies.
package prws_pkg;

  localparam int SLOTS       = 8;
  localparam int RETRY_DEPTH = 8;
  localparam int CHUNK_BYTES = 256;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int RSTK_W  = $clog2(RETRY_DEPTH);
  localparam int RCNT_W  = $clog2(RETRY_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [8:0] CHUNK_LEN = 9'(CHUNK_BYTES);
  localparam logic [3:0] MAX_DEPTH = 4'(SLOTS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_DEPTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_AFTER   = 3'd5;

  localparam logic [15:0] RESET_READ_TIMEOUT = 16'd400;
  localparam logic [15:0] RESET_QUIET        = 16'd300;
  localparam logic [7:0]  RESET_MAX_TIMEOUTS = 8'd40;
  localparam logic [3:0]  RESET_START_DEPTH  = 4'd2;
  localparam logic [7:0]  RESET_GROW_AFTER   = 8'd16;
  localparam logic [3:0]  RESET_DEPTH        = 4'd2;

  // event types
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_REPLY = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_FAILED  = 3'd3;
  localparam logic [2:0] KIND_REFUSED = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_RUN, MODE_DONE, MODE_FAIL
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_FILL_INIT, S_FILL, S_DONE_CHK,
    S_REPLY_B, S_FLUSH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_REFUSE, OP_FAIL, OP_SCAN, OP_FILL_INIT,
    OP_FILL, OP_DONE_CHK, OP_REPLY_A, OP_REPLY_B, OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [2:0]  reply_slot;
    logic        rsp_error;
    logic [8:0]  rsp_len;
    logic [3:0]  tx_room;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] offset;
    logic [8:0]  len;
    logic [31:0] total;
  } res_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       run;
    logic       target_zero;
    logic       reply_hit;
    logic       rsp_error;
    logic       go;
    logic       scan_fail;
    logic       idx_last;
    logic       fill_stop;
    logic       quiet;
  } status_t;

endpackage

>>> src/prws_if.sv
// Valid/ready channel interfaces for event words in and result words out.
// Depends on nothing.
interface prws_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic [2:0]  reply_slot;
  logic        rsp_error;
  logic [8:0]  rsp_len;
  logic [3:0]  tx_room;

  modport source (output valid, req_type, now_ms, reply_slot, rsp_error, rsp_len,
                  tx_room, input ready);
  modport sink (input valid, req_type, now_ms, reply_slot, rsp_error, rsp_len,
                tx_room, output ready);
endinterface

interface prws_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [2:0]  out_slot;
  logic [31:0] out_offset;
  logic [8:0]  out_len;
  logic [31:0] total_bytes;
  logic        last;

  modport source (output valid, out_kind, out_slot, out_offset, out_len,
                  total_bytes, last, input ready);
  modport sink (input valid, out_kind, out_slot, out_offset, out_len,
                total_bytes, last, output ready);
endinterface

>>> src/prws_ctrl.sv
// Read window scheduler sequencer: walks one event word through dispatch,
// slot scan, window fill, done check, reply and flush. Uses prws_pkg.
module prws_ctrl import prws_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.go) begin
          case (status.req_type)
            REQ_START: begin
              if (status.run || status.target_zero) begin
                cmd.op     = OP_REFUSE;
                state_next = S_FLUSH;
              end else begin
                cmd.op     = OP_START;
                state_next = S_FILL_INIT;
              end
            end
            REQ_STOP: begin
              if (status.run) cmd.op = OP_FAIL;
              state_next = S_FLUSH;
            end
            REQ_TICK: begin
              state_next = status.run ? S_SCAN : S_FLUSH;
            end
            default: begin
              if (status.run && status.reply_hit) begin
                if (status.rsp_error) begin
                  cmd.op     = OP_FAIL;
                  state_next = S_FLUSH;
                end else begin
                  cmd.op     = OP_REPLY_A;
                  state_next = S_REPLY_B;
                end
              end else begin
                state_next = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (status.go) begin
          cmd.op = OP_SCAN;
          if (status.scan_fail) state_next = S_FLUSH;
          else if (status.idx_last) state_next = S_FILL_INIT;
        end
      end
      S_FILL_INIT: begin
        cmd.op = OP_FILL_INIT;
        if (status.quiet) begin
          state_next = (status.req_type == REQ_TICK) ? S_DONE_CHK : S_FLUSH;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (status.go) begin
          cmd.op = OP_FILL;
          if (status.fill_stop || status.idx_last) begin
            state_next = (status.req_type == REQ_TICK) ? S_DONE_CHK : S_FLUSH;
          end
        end
      end
      S_DONE_CHK: begin
        if (status.go) begin
          cmd.op     = OP_DONE_CHK;
          state_next = S_FLUSH;
        end
      end
      S_REPLY_B: begin
        cmd.op     = OP_REPLY_B;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (status.go) begin
          cmd.op     = OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/prws_dp.sv
// Datapath of the read window scheduler: registers, slot table, retry stack,
// window arithmetic and the two-deep result buffer. Uses prws_pkg, prws_out_if.
module prws_dp import prws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_word_t              in_word,
  input  cmd_t                  cmd,
  output status_t               status,
  prws_out_if.source            out_ch
);

  logic [6:0]  node_id;
  logic [15:0] read_timeout;
  logic [15:0] quiet_ms;
  logic [7:0]  max_timeouts;
  logic [3:0]  start_depth;
  logic [7:0]  grow_after;

  in_word_t    lat;
  mode_t       mode;
  logic [SLOTS-1:0] busy;
  logic [31:0] soff   [SLOTS];
  logic [31:0] stime  [SLOTS];
  logic [31:0] rstack [RETRY_DEPTH];
  logic [RCNT_W-1:0] rcount;
  logic [31:0] nro, endo, quiet_until, byte_total;
  logic        ek;
  logic [3:0]  depth;
  logic [15:0] good_run;
  logic [7:0]  tcount;
  logic [SLOT_W-1:0] idx;
  logic [3:0]  inflight;
  logic [3:0]  room;
  logic [8:0]  lsat;

  res_t pend, outr;
  logic pend_valid, out_valid, out_last;

  // combinational
  logic [SLOT_W-1:0] ra;
  logic [31:0] off_r, age, top_off, fill_off, end_c;
  logic        timed_out, past_end, tc_ovf, has_retry, can_new, avail;
  logic        fill_stop, fill_issue, scan_fail, done_ok, go;
  logic [8:0]  tc_inc, lsat_c;
  logic [RCNT_W-1:0] rc_m1;
  logic [11:0] thr;
  logic [15:0] gr1;
  logic [3:0]  sd_clamp;
  logic        emit_en;
  res_t        emit_rec;

  assign ra        = (cmd.op == OP_REPLY_A || cmd.op == OP_REPLY_B) ?
                     lat.reply_slot : idx;
  assign off_r     = soff[ra];
  assign age       = lat.now_ms - stime[idx];
  assign timed_out = age > {16'd0, read_timeout};
  assign past_end  = ek && (off_r >= endo);
  assign tc_inc    = {1'b0, tcount} + 9'd1;
  assign tc_ovf    = tc_inc > {1'b0, max_timeouts};
  assign scan_fail = busy[idx] && !past_end && timed_out && tc_ovf;

  assign rc_m1     = rcount - RCNT_W'(1);
  assign top_off   = rstack[rc_m1[RSTK_W-1:0]];
  assign has_retry = rcount != '0;
  assign can_new   = !ek || (nro < endo);
  assign avail     = has_retry || can_new;
  assign fill_off  = has_retry ? top_off : nro;
  assign fill_stop = (inflight >= depth) || (!busy[idx] && avail && room == 4'd0);
  assign fill_issue = !fill_stop && !busy[idx] && avail;

  assign lsat_c = (lat.rsp_len > CHUNK_LEN) ? CHUNK_LEN : lat.rsp_len;
  assign thr    = {8'd0, depth} * {4'd0, grow_after};
  assign gr1    = good_run + 16'd1;
  assign end_c  = off_r + {23'd0, lsat};

  assign done_ok = ek && !(|busy) && rcount == '0 && nro >= endo;

  assign sd_clamp = (start_depth == 4'd0) ? 4'd1 :
                    (start_depth > MAX_DEPTH) ? MAX_DEPTH : start_depth;

  // a new result may be taken when the pending one can move to the output
  assign go = !pend_valid || !out_valid || out_ch.ready;

  always_comb begin
    emit_en  = 1'b0;
    emit_rec = '{kind: KIND_FAILED, slot: 3'd0, offset: 32'd0, len: 9'd0,
                 total: byte_total};
    case (cmd.op)
      OP_REFUSE: begin
        emit_en       = 1'b1;
        emit_rec.kind = KIND_REFUSED;
      end
      OP_FAIL:   emit_en = 1'b1;
      OP_SCAN:   emit_en = scan_fail;
      OP_FILL: begin
        emit_en         = fill_issue;
        emit_rec.kind   = KIND_READ;
        emit_rec.slot   = 3'(idx);
        emit_rec.offset = fill_off;
      end
      OP_DONE_CHK: begin
        emit_en        = done_ok;
        emit_rec.kind  = KIND_DONE;
        emit_rec.total = endo;
      end
      OP_REPLY_A: begin
        emit_en         = lsat_c != 9'd0;
        emit_rec.kind   = KIND_WRITE;
        emit_rec.slot   = lat.reply_slot;
        emit_rec.offset = off_r;
        emit_rec.len    = lsat_c;
        emit_rec.total  = byte_total + {23'd0, lsat_c};
      end
      default: emit_en = 1'b0;
    endcase
  end

  always_comb begin
    status.req_type    = lat.req_type;
    status.run         = mode == MODE_RUN;
    status.target_zero = node_id == 7'd0;
    status.reply_hit   = busy[lat.reply_slot];
    status.rsp_error   = lat.rsp_error;
    status.go          = go;
    status.scan_fail   = scan_fail;
    status.idx_last    = idx == SLOT_W'(SLOTS - 1);
    status.fill_stop   = fill_stop;
    status.quiet       = lat.now_ms < quiet_until;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id      <= 7'd0;
      read_timeout <= RESET_READ_TIMEOUT;
      quiet_ms     <= RESET_QUIET;
      max_timeouts <= RESET_MAX_TIMEOUTS;
      start_depth  <= RESET_START_DEPTH;
      grow_after   <= RESET_GROW_AFTER;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NODE_ID:      node_id      <= cfg_data[6:0];
        REG_READ_TIMEOUT: read_timeout <= cfg_data;
        REG_QUIET:        quiet_ms     <= cfg_data;
        REG_MAX_TIMEOUTS: max_timeouts <= cfg_data[7:0];
        REG_START_DEPTH:  start_depth  <= cfg_data[3:0];
        REG_GROW_AFTER:   grow_after   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // tables and latched word: no reset
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) lat <= in_word;
    if (cmd.op == OP_REPLY_A) lsat <= lsat_c;
    if (cmd.op == OP_FILL_INIT) begin
      inflight <= 4'($countones(busy));
      room     <= lat.tx_room;
    end
    if (cmd.op == OP_FILL && fill_issue) begin
      soff[idx]  <= fill_off;
      stime[idx] <= lat.now_ms;
      room       <= room - 4'd1;
      inflight   <= inflight + 4'd1;
    end
    if (cmd.op == OP_SCAN && busy[idx] && !past_end && timed_out && !tc_ovf &&
        rcount < RCNT_W'(RETRY_DEPTH)) begin
      rstack[rcount[RSTK_W-1:0]] <= off_r;
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      busy        <= '0;
      rcount      <= '0;
      nro         <= 32'd0;
      endo        <= 32'd0;
      ek          <= 1'b0;
      depth       <= RESET_DEPTH;
      good_run    <= 16'd0;
      tcount      <= 8'd0;
      quiet_until <= 32'd0;
      byte_total  <= 32'd0;
      idx         <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD, OP_FILL_INIT: idx <= '0;
        OP_START: begin
          byte_total  <= 32'd0;
          rcount      <= '0;
          quiet_until <= 32'd0;
          tcount      <= 8'd0;
          depth       <= sd_clamp;
          good_run    <= 16'd0;
          nro         <= 32'd0;
          endo        <= 32'd0;
          ek          <= 1'b0;
          busy        <= '0;
          mode        <= MODE_RUN;
        end
        OP_FAIL: begin
          busy <= '0;
          mode <= MODE_FAIL;
        end
        OP_SCAN: begin
          idx <= idx + SLOT_W'(1);
          if (busy[idx]) begin
            if (past_end) begin
              busy[idx] <= 1'b0;
            end else if (timed_out) begin
              if (tc_ovf) begin
                busy <= '0;
                mode <= MODE_FAIL;
              end else begin
                busy[idx]   <= 1'b0;
                tcount      <= tc_inc[7:0];
                depth       <= (depth > 4'd1) ? (depth >> 1) : 4'd1;
                good_run    <= 16'd0;
                quiet_until <= lat.now_ms + {16'd0, quiet_ms};
                if (rcount < RCNT_W'(RETRY_DEPTH)) rcount <= rcount + RCNT_W'(1);
              end
            end
          end
        end
        OP_FILL: begin
          idx <= idx + SLOT_W'(1);
          if (fill_issue) begin
            busy[idx] <= 1'b1;
            if (has_retry) rcount <= rc_m1;
            else nro <= nro + 32'(CHUNK_BYTES);
          end
        end
        OP_DONE_CHK: begin
          if (done_ok) begin
            byte_total <= endo;
            mode       <= MODE_DONE;
          end
        end
        OP_REPLY_A: begin
          busy[lat.reply_slot] <= 1'b0;
          byte_total <= byte_total + {23'd0, lsat_c};
        end
        OP_REPLY_B: begin
          if ({12'd0, gr1} >= {16'd0, thr}) begin
            good_run <= 16'd0;
            if (depth < MAX_DEPTH) depth <= depth + 4'd1;
          end else begin
            good_run <= gr1;
          end
          if (lsat < CHUNK_LEN && (!ek || end_c < endo)) begin
            endo <= end_c;
            ek   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result buffer: pend holds the newest result until it is known whether it
  // closes the event
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_en) begin
        pend_valid <= 1'b1;
        if (pend_valid) out_valid <= 1'b1;
        else if (out_ch.ready) out_valid <= 1'b0;
      end else if (cmd.op == OP_FLUSH && pend_valid) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      pend <= emit_rec;
      if (pend_valid) begin
        outr     <= pend;
        out_last <= 1'b0;
      end
    end else if (cmd.op == OP_FLUSH && pend_valid) begin
      outr     <= pend;
      out_last <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_kind    = outr.kind;
  assign out_ch.out_slot    = outr.slot;
  assign out_ch.out_offset  = outr.offset;
  assign out_ch.out_len     = outr.len;
  assign out_ch.total_bytes = outr.total;
  assign out_ch.last        = out_last;

endmodule

>>> src/pipelined_read_window_scheduler_unit.sv
// Top level of the pipelined read window scheduler: controller plus datapath.
// Uses prws_pkg, prws_if, prws_ctrl, prws_dp.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    req_type now_ms reply_slot rsp_error rsp_len tx_room
//   out_ch    out  valid/ready    out_kind out_slot out_offset out_len total_bytes last
//   cfg       in   cfg_wr_en      cfg_index cfg_data (no read-back)
//
// One event word at a time. A reply passes dispatch, reply update and flush; a
// start passes dispatch, window fill and flush; a running tick adds a slot scan
// before the fill and a done check after it. The eight-slot scan and fill walk one
// slot per cycle unless stalled, the fill ends early once window or room is used up.
// Output stalls hold the sequencer at each scan and fill step and at the next
// result; one result may wait at the output while the next event is taken.
// Synchronous active-high reset; no clearing pass.
module pipelined_read_window_scheduler_unit import prws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  prws_in_if.sink               in_ch,
  prws_out_if.source            out_ch
);

  cmd_t     cmd;
  status_t  status;
  in_word_t in_word;
  logic     in_ready;

  assign in_word = '{req_type: in_ch.req_type, now_ms: in_ch.now_ms,
                     reply_slot: in_ch.reply_slot, rsp_error: in_ch.rsp_error,
                     rsp_len: in_ch.rsp_len, tx_room: in_ch.tx_room};
  assign in_ch.ready = in_ready;

  prws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  prws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

endmodule
